>>> rtl/pimdc_pkg.sv
package pimdc_pkg;

    // input item kinds
    localparam logic [1:0] CMD_CAPTURE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_POLL    = 2'd2;

    // channel classes
    localparam logic [1:0] MODE_HIGH = 2'd0;
    localparam logic [1:0] MODE_PWM  = 2'd1;
    localparam logic [1:0] MODE_LOW  = 2'd2;

    // configuration register indexes
    localparam logic [0:0] REG_PERIOD  = 1'd0;
    localparam logic [0:0] REG_TIMEOUT = 1'd1;

    localparam logic [15:0] PERIOD_RESET  = 16'd62600;
    localparam logic [15:0] TIMEOUT_RESET = 16'd5;

    // fixed-point shift for the per-mille scale factors
    localparam int SCALE_SHIFT = 28;

    function automatic logic [28:0] scale_mult(input int unsigned k);
        logic [63:0] v;
        v = ((64'(k) << SCALE_SHIFT) + 64'd999) / 64'd1000;
        return v[28:0];
    endfunction

    localparam logic [28:0] MULT_266 = scale_mult(266);
    localparam logic [28:0] MULT_389 = scale_mult(389);
    localparam logic [28:0] MULT_512 = scale_mult(512);
    localparam logic [28:0] MULT_630 = scale_mult(630);
    localparam logic [28:0] MULT_750 = scale_mult(750);
    localparam logic [28:0] MULT_872 = scale_mult(872);

    typedef struct packed {
        logic        live;
        logic [15:0] mean;
    } t_chan_stat;

    typedef struct packed {
        logic [1:0]  right_mode;
        logic [1:0]  left_mode;
        logic [15:0] compare;
        logic        dir_b;
        logic        dir_a;
        logic        standby;
    } t_result;

endpackage

>>> rtl/pwm_input_motor_drive_converter_top.sv
// path: a poll request goes through the input register and then the single result register
// (one in flight), and waits in the input register while the result is stalled;
// throughput: one request per cycle unless a poll waits; capture and tick requests give no result
// reset: synchronous, active low; clears all channel state, held drive and
// output valid, and loads the output period 62600 and the timeout 5
module pwm_input_motor_drive_converter_top #(
    parameter int SAMPLES = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pulse_width[15:0], pin_level_right[16],
                                   // pin_level_left[17], zero fill[23:18]
    input  logic [2:0]  s_tuser,   // command[1:0], channel[2]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // motor_standby[0], motor_dir_a[1],
                                   // motor_dir_b[2], duty_compare[18:3],
                                   // left_mode[20:19], right_mode[22:21],
                                   // zero fill[23]
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data
);

    // configuration registers
    logic [15:0] r_period;
    logic [15:0] r_timeout;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic        r_chan;
    logic [15:0] r_pw;
    logic        r_pin_r;
    logic        r_pin_l;

    // result register
    logic        r_out_valid;
    pimdc_pkg::t_result r_out;

    logic w_out_free;
    logic w_fire;
    logic w_is_poll;

    pimdc_pkg::t_chan_stat w_right_stat;
    pimdc_pkg::t_chan_stat w_left_stat;
    pimdc_pkg::t_result    w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= pimdc_pkg::PERIOD_RESET;
            r_timeout <= pimdc_pkg::TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pimdc_pkg::REG_PERIOD:  r_period  <= i_cfg_data;
                pimdc_pkg::REG_TIMEOUT: r_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // a poll needs a free result slot, everything else always goes through
    assign w_is_poll  = (r_cmd == pimdc_pkg::CMD_POLL);
    assign w_out_free = !r_out_valid || m_tready;
    assign w_fire     = r_in_valid && (!w_is_poll || w_out_free);
    assign s_tready   = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_cmd   <= s_tuser[1:0];
            r_chan  <= s_tuser[2];
            r_pw    <= s_tdata[15:0];
            r_pin_r <= s_tdata[16];
            r_pin_l <= s_tdata[17];
        end
    end

    // right channel is index 0, left is index 1
    pimdc_chan #(.SAMPLES(SAMPLES)) u_chan_right (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_fire),
        .i_cmd         (r_cmd),
        .i_sel         (!r_chan),
        .i_pulse_width (r_pw),
        .i_timeout     (r_timeout),
        .o_stat        (w_right_stat)
    );

    pimdc_chan #(.SAMPLES(SAMPLES)) u_chan_left (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_fire),
        .i_cmd         (r_cmd),
        .i_sel         (r_chan),
        .i_pulse_width (r_pw),
        .i_timeout     (r_timeout),
        .o_stat        (w_left_stat)
    );

    // classing, band lookup and held drive lines
    pimdc_drive u_drive (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_fire && w_is_poll),
        .i_period    (r_period),
        .i_right     (w_right_stat),
        .i_left      (w_left_stat),
        .i_pin_right (r_pin_r),
        .i_pin_left  (r_pin_l),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_poll) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_poll) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out.right_mode, r_out.left_mode, r_out.compare,
                       r_out.dir_b, r_out.dir_a, r_out.standby};

endmodule

>>> rtl/pimdc_chan.sv
module pimdc_chan #(
    parameter int SAMPLES = 100
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [1:0]            i_cmd,
    input  logic                  i_sel,
    input  logic [15:0]           i_pulse_width,
    input  logic [15:0]           i_timeout,
    output pimdc_pkg::t_chan_stat o_stat
);

    // ceil(2^32 / SAMPLES) gives an exact quotient for any 24-bit sum
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
    localparam logic [7:0] COUNT_LIMIT = 8'(SAMPLES);

    logic        r_seen;
    logic [15:0] r_age;
    logic [23:0] r_sum;
    logic [7:0]  r_count;
    logic [15:0] r_mean;

    logic [23:0] n_sum;
    logic [7:0]  n_count;
    logic [56:0] w_prod;
    logic        w_live;
    logic        w_full;

    assign n_sum   = r_sum + 24'(i_pulse_width);
    assign n_count = r_count + 8'd1;
    assign w_full  = (n_count >= COUNT_LIMIT);
    assign w_prod  = 57'(n_sum) * 57'(RECIP);
    assign w_live  = r_seen && !(r_age > i_timeout);

    assign o_stat.live = w_live;
    assign o_stat.mean = r_mean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= 1'b0;
            r_age   <= '0;
            r_sum   <= '0;
            r_count <= '0;
            r_mean  <= '0;
        end else if (i_step) begin
            case (i_cmd)
                pimdc_pkg::CMD_CAPTURE: begin
                    if (i_sel) begin
                        r_seen <= 1'b1;
                        r_age  <= '0;
                        if (w_full) begin
                            r_mean  <= w_prod[47:32];
                            r_sum   <= '0;
                            r_count <= '0;
                        end else begin
                            r_sum   <= n_sum;
                            r_count <= n_count;
                        end
                    end
                end
                pimdc_pkg::CMD_TICK: begin
                    if (r_age != 16'hFFFF) begin
                        r_age <= r_age + 16'd1;
                    end
                end
                pimdc_pkg::CMD_POLL: begin
                    r_seen <= w_live;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/pimdc_drive.sv
module pimdc_drive (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_update,
    input  logic [15:0]           i_period,
    input  pimdc_pkg::t_chan_stat i_right,
    input  pimdc_pkg::t_chan_stat i_left,
    input  logic                  i_pin_right,
    input  logic                  i_pin_left,
    output pimdc_pkg::t_result    o_result
);

    logic [2:0]  r_lines;      // standby, dir_a, dir_b
    logic [15:0] r_compare;

    logic [2:0]  n_lines;
    logic [15:0] n_compare;

    logic [1:0]  w_lmode;
    logic [1:0]  w_rmode;
    logic [1:0]  w_side_mode;
    logic [15:0] w_side_mean;
    logic [28:0] w_mult;
    logic        w_in_band;
    logic [44:0] w_prod;
    logic [15:0] w_side_cmp;

    assign w_rmode = i_right.live ? pimdc_pkg::MODE_PWM
                   : (i_pin_right ? pimdc_pkg::MODE_HIGH : pimdc_pkg::MODE_LOW);
    assign w_lmode = i_left.live ? pimdc_pkg::MODE_PWM
                   : (i_pin_left ? pimdc_pkg::MODE_HIGH : pimdc_pkg::MODE_LOW);

    // the side that is not high sets the compare value
    assign w_side_mode = (w_lmode == pimdc_pkg::MODE_HIGH) ? w_rmode : w_lmode;
    assign w_side_mean = (w_lmode == pimdc_pkg::MODE_HIGH) ? i_right.mean : i_left.mean;

    always_comb begin
        w_in_band = 1'b1;
        case (w_side_mean) inside
            [16'd1400:16'd1600]: w_mult = pimdc_pkg::MULT_266;
            [16'd1150:16'd1350]: w_mult = pimdc_pkg::MULT_389;
            [16'd900:16'd1100]:  w_mult = pimdc_pkg::MULT_512;
            [16'd650:16'd850]:   w_mult = pimdc_pkg::MULT_630;
            [16'd400:16'd600]:   w_mult = pimdc_pkg::MULT_750;
            [16'd150:16'd350]:   w_mult = pimdc_pkg::MULT_872;
            default: begin
                w_mult    = '0;
                w_in_band = 1'b0;
            end
        endcase
    end

    assign w_prod = 45'(i_period) * 45'(w_mult);
    assign w_side_cmp = (w_side_mode == pimdc_pkg::MODE_PWM && w_in_band)
                      ? w_prod[pimdc_pkg::SCALE_SHIFT +: 16] : i_period;

    always_comb begin
        n_lines   = r_lines;
        n_compare = r_compare;
        if (w_lmode == pimdc_pkg::MODE_HIGH && w_rmode == pimdc_pkg::MODE_HIGH) begin
            n_lines   = 3'b000;
            n_compare = '0;
        end else if (w_lmode == pimdc_pkg::MODE_HIGH) begin
            n_lines   = 3'b101;
            n_compare = w_side_cmp;
        end else if (w_rmode == pimdc_pkg::MODE_HIGH) begin
            n_lines   = 3'b110;
            n_compare = w_side_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines   <= '0;
            r_compare <= '0;
        end else if (i_update) begin
            r_lines   <= n_lines;
            r_compare <= n_compare;
        end
    end

    assign o_result.standby    = n_lines[2];
    assign o_result.dir_a      = n_lines[1];
    assign o_result.dir_b      = n_lines[0];
    assign o_result.compare    = n_compare;
    assign o_result.left_mode  = w_lmode;
    assign o_result.right_mode = w_rmode;

endmodule

>>> rtl/pimdc_checker.sv
module pimdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // no result right after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // standby follows exactly one active direction line
    a_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] ^ m_tdata[2])) && !(m_tdata[1] && m_tdata[2]))
        else $error("inconsistent drive lines");

    // both inputs high puts the driver in standby with zero compare
    a_both_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[20:19] == pimdc_pkg::MODE_HIGH
                 && m_tdata[22:21] == pimdc_pkg::MODE_HIGH
        |-> !m_tdata[0] && m_tdata[18:3] == 16'd0)
        else $error("high/high not in standby");

    // right high and left active drives left
    a_left_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[22:21] == pimdc_pkg::MODE_HIGH
                 && m_tdata[20:19] != pimdc_pkg::MODE_HIGH
        |-> m_tdata[0] && m_tdata[1])
        else $error("left drive not selected");

endmodule

bind pwm_input_motor_drive_converter_top pimdc_checker u_pimdc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
);

>>> tb/pimdc_drive_checker.sv
// watches both streams and the config port, predicts every poll result
// and compares it field by field with what the block returns
module pimdc_drive_checker
    import pimdc_pkg::*;
#(
    parameter int SAMPLES = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [23:0] i_req_data,
    input  logic [2:0]  i_req_user,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [23:0] i_res_data,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_checked
);

    // shadow registers
    logic [15:0] period;
    logic [15:0] timeout;

    // per channel, index 0 right, index 1 left
    logic        live [2];
    logic [15:0] age [2];
    logic [23:0] width_acc [2];
    logic [7:0]  width_cnt [2];
    logic [15:0] mean [2];

    t_result     held_drive;
    t_result     drive_q [$];
    int          fails = 0;
    int          checked = 0;

    function automatic logic [15:0] duty_for_width(input logic [15:0] w);
        logic [31:0] k;
        if (w >= 1400 && w <= 1600) k = 266;
        else if (w >= 1150 && w <= 1350) k = 389;
        else if (w >= 900 && w <= 1100) k = 512;
        else if (w >= 650 && w <= 850) k = 630;
        else if (w >= 400 && w <= 600) k = 750;
        else if (w >= 150 && w <= 350) k = 872;
        else return period;
        return 16'((32'(period) * k) / 32'd1000);
    endfunction

    task automatic apply_request(input logic [1:0] cmd, input logic ch,
                                 input logic [15:0] pw, input logic pin_r,
                                 input logic pin_l);
        logic [1:0] rm;
        logic [1:0] lm;
        t_result    res;
        case (cmd)
            CMD_CAPTURE: begin
                width_acc[ch] = width_acc[ch] + 24'(pw);
                width_cnt[ch] = width_cnt[ch] + 8'd1;
                if (width_cnt[ch] >= SAMPLES) begin
                    mean[ch] = 16'(width_acc[ch] / SAMPLES);
                    width_cnt[ch] = '0;
                    width_acc[ch] = '0;
                end
                live[ch] = 1'b1;
                age[ch] = '0;
            end
            CMD_TICK: begin
                for (int i = 0; i < 2; i++)
                    if (age[i] != 16'hFFFF) age[i] = age[i] + 16'd1;
            end
            CMD_POLL: begin
                // stale pulse flags drop first
                for (int i = 0; i < 2; i++)
                    if (live[i] && age[i] > timeout) live[i] = 1'b0;
                rm = live[0] ? MODE_PWM : (pin_r ? MODE_HIGH : MODE_LOW);
                lm = live[1] ? MODE_PWM : (pin_l ? MODE_HIGH : MODE_LOW);
                if (lm == MODE_HIGH && rm == MODE_HIGH) begin
                    held_drive = '0;
                end else if (lm == MODE_HIGH) begin
                    held_drive.standby = 1'b1;
                    held_drive.dir_a = 1'b0;
                    held_drive.dir_b = 1'b1;
                    held_drive.compare = (rm == MODE_PWM) ? duty_for_width(mean[0]) : period;
                end else if (rm == MODE_HIGH) begin
                    held_drive.standby = 1'b1;
                    held_drive.dir_a = 1'b1;
                    held_drive.dir_b = 1'b0;
                    held_drive.compare = (lm == MODE_PWM) ? duty_for_width(mean[1]) : period;
                end
                res = held_drive;
                res.left_mode = lm;
                res.right_mode = rm;
                drive_q.push_back(res);
            end
            default: ;
        endcase
    endtask

    task automatic report_field(input string field, input int want, input int got);
        if (want != got) begin
            fails++;
            if (fails <= 10)
                $display("%0t: drive mismatch in %s: expected %0d, got %0d",
                         $realtime, field, want, got);
        end
    endtask

    task automatic check_result(input logic [23:0] data);
        t_result got;
        t_result want;
        got = t_result'(data[22:0]);
        if (drive_q.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("%0t: drive result with nothing pending: %h", $realtime, data);
        end else begin
            want = drive_q.pop_front();
            checked++;
            report_field("motor_standby", int'(want.standby), int'(got.standby));
            report_field("motor_dir_a", int'(want.dir_a), int'(got.dir_a));
            report_field("motor_dir_b", int'(want.dir_b), int'(got.dir_b));
            report_field("duty_compare", int'(want.compare), int'(got.compare));
            report_field("left_mode", int'(want.left_mode), int'(got.left_mode));
            report_field("right_mode", int'(want.right_mode), int'(got.right_mode));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            period = PERIOD_RESET;
            timeout = TIMEOUT_RESET;
            for (int i = 0; i < 2; i++) begin
                live[i] = 1'b0;
                age[i] = '0;
                width_acc[i] = '0;
                width_cnt[i] = '0;
                mean[i] = '0;
            end
            held_drive = '0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_PERIOD:  period = i_cfg_data;
                    REG_TIMEOUT: timeout = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                apply_request(i_req_user[1:0], i_req_user[2], i_req_data[15:0],
                              i_req_data[16], i_req_data[17]);
            if (i_res_valid && i_res_ready)
                check_result(i_res_data);
        end
        o_fail_count <= fails;
        o_pending <= drive_q.size();
        o_results_checked <= checked;
    end

endmodule

>>> tb/tb.sv
// stimulus and verdict for the pwm input to motor drive converter
module tb;
    import pimdc_pkg::*;

    localparam int SAMPLES = 100;
    localparam int LIMIT = 100_000;
    // poll result passes the input and result registers after acceptance, allow some margin
    localparam int SETTLE_CYCLES = 6;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int AGE_TIMEOUT = 10;
    localparam int AGE_SHORT = 10;
    localparam int AGE_LONG = 11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // pulse_width[15:0], pin_level_right[16],
                                  // pin_level_left[17], zero fill[23:18]
    logic [2:0]  s_tuser = '0;    // command[1:0], channel[2]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // motor_standby[0], motor_dir_a[1], motor_dir_b[2],
                                  // duty_compare[18:3], left_mode[20:19],
                                  // right_mode[22:21], zero fill[23]
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int results_checked;
    int n_cycles = 0;
    int n_requests = 0;
    int n_settings = 0;
    bit calm = 1'b0;   // no idling on either side while set

    // widths on and around every band edge, plus the field extremes
    int band_widths [] = '{0, 149, 150, 151, 250, 349, 350, 351, 399, 400, 500, 600,
                           601, 649, 650, 750, 850, 851, 899, 900, 1000, 1100, 1101,
                           1149, 1150, 1250, 1350, 1351, 1399, 1400, 1500, 1600,
                           1601, 65535};

    always #2 i_clk = ~i_clk;

    pwm_input_motor_drive_converter_top #(
        .SAMPLES(SAMPLES)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data)
    );

    pimdc_drive_checker #(
        .SAMPLES(SAMPLES)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (s_tvalid),
        .i_req_ready      (s_tready),
        .i_req_data       (s_tdata),
        .i_req_user       (s_tuser),
        .i_res_valid      (m_tvalid),
        .i_res_ready      (m_tready),
        .i_res_data       (m_tdata),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_results_checked(results_checked)
    );

    // result side back-pressure, about a quarter of cycles stalled
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(99) >= 24);
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= LIMIT) begin
            $display("run stopped after %0d cycles with %0d results pending",
                     n_cycles, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one request; valid stays high into the next request when no gap is drawn
    task automatic send_request(input logic [1:0] cmd, input logic ch,
                                input logic [15:0] pw, input logic pin_r,
                                input logic pin_l);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {ch, cmd};
        s_tdata <= {6'd0, pin_l, pin_r, pw};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (cmd != CMD_UNUSED) n_requests++;
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, 1'($urandom_range(1)), 16'($urandom_range(65535)),
                     1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic send_poll(input logic pin_r, input logic pin_l);
        send_request(CMD_POLL, 1'($urandom_range(1)), 16'($urandom_range(65535)),
                     pin_r, pin_l);
    endtask

    // stop sending and wait until every poll has been answered
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // block is idle here, write both registers back to back
    task automatic set_config(input logic [15:0] period, input logic [15:0] timeout);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_addr <= REG_TIMEOUT;
        i_cfg_data <= timeout;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic directed_part();
        // both pins high, then low, then each mixed combination
        send_poll(1'b1, 1'b1);
        send_poll(1'b0, 1'b0);
        send_poll(1'b0, 1'b1);
        send_poll(1'b1, 1'b0);
        send_poll(1'b1, 1'b1);
        // unused command must leave everything alone
        send_request(CMD_UNUSED, 1'b1, 16'hFFFF, 1'b1, 1'b1);
        send_request(CMD_UNUSED, 1'b0, 16'h0000, 1'b0, 1'b0);
        // width extremes on both channels, both pwm keeps the last drive
        send_request(CMD_CAPTURE, 1'b0, 16'hFFFF, 1'b0, 1'b0);
        send_request(CMD_CAPTURE, 1'b1, 16'h0000, 1'b1, 1'b1);
        send_poll(1'b1, 1'b1);
        send_poll(1'b0, 1'b1);
        // one tick past the timeout drops both flags
        repeat (int'(TIMEOUT_RESET) + 1) send_tick();
        send_poll(1'b1, 1'b1);
        // right live, left high: right drive from a mean outside all bands
        send_request(CMD_CAPTURE, 1'b0, 16'h5555, 1'b0, 1'b1);
        send_poll(1'b0, 1'b1);
        send_request(CMD_CAPTURE, 1'b1, 16'hAAAA, 1'b1, 1'b0);
        send_poll(1'b1, 1'b0);
        send_poll(1'b0, 1'b0);
    endtask

    // timeout edge: age equal to the timeout keeps the flag, one more tick drops it
    task automatic age_run();
        send_request(CMD_CAPTURE, 1'b0, 16'd1000, 1'b1, 1'b1);
        send_request(CMD_CAPTURE, 1'b1, 16'd500, 1'b1, 1'b1);
        repeat (AGE_SHORT) send_tick();
        send_poll(1'b1, 1'b1);   // age equals timeout, still pwm
        send_request(CMD_CAPTURE, 1'b0, 16'd1000, 1'b1, 1'b1);
        send_request(CMD_CAPTURE, 1'b1, 16'd500, 1'b1, 1'b1);
        repeat (AGE_LONG) send_tick();
        send_poll(1'b1, 1'b0);
        send_poll(1'b0, 1'b1);
    endtask

    // mostly full capture bursts on one channel with ticks and polls mixed in,
    // the rest fully random requests
    task automatic random_phase(input int n_items);
        int   start;
        int   len;
        logic ch;
        logic [15:0] target;
        bit   spread;
        start = n_requests;
        while (n_requests - start < n_items) begin
            if ($urandom_range(99) < 82) begin
                ch = 1'($urandom_range(1));
                target = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                       : 16'(band_widths[$urandom_range(band_widths.size() - 1)]);
                spread = ($urandom_range(4) == 0);
                len = ($urandom_range(4) == 0) ? $urandom_range(1, SAMPLES - 1) : SAMPLES;
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 8) send_tick();
                    if ($urandom_range(99) < 6)
                        send_poll(1'($urandom_range(1)), 1'($urandom_range(1)));
                    send_request(CMD_CAPTURE, ch, spread ? 16'($urandom_range(65535)) : target,
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                end
                repeat ($urandom_range(0, 8)) send_tick();
                repeat ($urandom_range(1, 3))
                    send_poll(1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                repeat (16)
                    send_request(2'($urandom_range(3)), 1'($urandom_range(1)),
                                 16'($urandom_range(65535)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(PERIOD_RESET, TIMEOUT_RESET);
        directed_part();
        drain();

        set_config(16'd65535, 16'(AGE_TIMEOUT));
        age_run();
        drain();

        // period extremes with timeout 0 and 3, a calm run, the reset values, then a random setting
        set_config(16'd65535, 16'd0);
        random_phase(280);
        drain();
        set_config(16'd0, 16'd3);
        random_phase(280);
        drain();
        calm = 1'b1;
        set_config(16'd1000, 16'd12);
        random_phase(280);
        drain();
        calm = 1'b0;
        set_config(PERIOD_RESET, TIMEOUT_RESET);
        random_phase(280);
        drain();
        set_config(16'($urandom_range(65535)), 16'($urandom_range(1, 10)));
        random_phase(280);
        drain();

        $display("%0d requests sent under %0d register settings, timeout edges included",
                 n_requests, n_settings);
        $display("%0d drive results compared, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> pwm_input_motor_drive_converter_top.f
rtl/pimdc_pkg.sv
rtl/pimdc_chan.sv
rtl/pimdc_drive.sv
rtl/pwm_input_motor_drive_converter_top.sv
rtl/pimdc_checker.sv
tb/pimdc_drive_checker.sv
tb/tb.sv
